/* src/pgp_pkg.sv */
// ----------------------------------------------------------------------------
// pgp_pkg: shared types and constants of the gray4 packer
// Source format codes, register indexes and the front/back queue word.
// ----------------------------------------------------------------------------
package pgp_pkg;

  // default depth of the front-to-back queue
  localparam int QUEUE_DEPTH = 4;

  // source format codes
  localparam logic [2:0] FMT_MONO   = 3'd0;
  localparam logic [2:0] FMT_GRAY4  = 3'd1;
  localparam logic [2:0] FMT_GRAY8  = 3'd2;
  localparam logic [2:0] FMT_RGB565 = 3'd3;
  localparam logic [2:0] FMT_ARGB   = 3'd4;
  localparam logic [2:0] FMT_RESET  = FMT_GRAY4;

  // register index within the configuration space
  localparam logic REG_SOURCE_FORMAT = 1'b0;

  // queue word: one converted nibble and its end-of-bitmap flag
  typedef struct packed {
    logic [3:0] nib;
    logic       last;
  } qword_t;

endpackage

/* src/pgp_front.sv */
// ----------------------------------------------------------------------------
// pgp_front: pixel intake and conversion
// Classifies each pixel by source format, widens color components into a
// register stage, then gives the queue direct or inverted luminance nibbles.
// ----------------------------------------------------------------------------
module pgp_front import pgp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [2:0]  fmt,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_pixel_value,
  input  logic        in_last_pixel,
  output logic        q_push,
  output qword_t      q_data,
  input  logic        q_full
);

  typedef enum logic [1:0] {
    KIND_DIRECT = 2'd0,
    KIND_GRAY   = 2'd1,
    KIND_LUMA   = 2'd2
  } kind_t;

  // 5-bit to 8-bit component widening
  function automatic logic [7:0] widen5(input logic [4:0] c);
    logic [15:0] prod;
    prod = 16'(c) * 16'd2106;
    return prod[15:8];
  endfunction

  // 6-bit to 8-bit component widening
  function automatic logic [7:0] widen6(input logic [5:0] c);
    logic [15:0] prod;
    prod = 16'(c) * 16'd1036;
    return prod[15:8];
  endfunction

  logic        s1_valid_r, s1_valid_nxt;
  kind_t       s1_kind_r, s1_kind_nxt;
  logic [3:0]  s1_nib_r, s1_nib_nxt;
  logic [7:0]  s1_r_r, s1_r_nxt;
  logic [7:0]  s1_g_r, s1_g_nxt;
  logic [7:0]  s1_b_r, s1_b_nxt;
  logic        s1_last_r;
  logic        adv;
  logic [15:0] luma_sum;
  logic [7:0]  y;
  logic [8:0]  inv;
  logic [3:0]  gray_nib;

  // stage moves when empty or when the queue takes its word
  assign adv      = !s1_valid_r || !q_full;
  assign in_stall = !adv;
  assign q_push   = s1_valid_r && !q_full;

  // classify and widen
  always_comb begin
    s1_kind_nxt = KIND_DIRECT;
    s1_nib_nxt  = 4'd0;
    s1_r_nxt    = 8'd0;
    s1_g_nxt    = 8'd0;
    s1_b_nxt    = 8'd0;
    case (fmt)
      FMT_MONO: begin
        s1_nib_nxt = {4{in_pixel_value[0]}};
      end
      FMT_GRAY4: begin
        s1_nib_nxt = in_pixel_value[3:0];
      end
      FMT_GRAY8: begin
        s1_kind_nxt = KIND_GRAY;
        s1_g_nxt    = in_pixel_value[7:0];
      end
      FMT_RGB565: begin
        s1_kind_nxt = KIND_LUMA;
        s1_r_nxt    = widen5(in_pixel_value[15:11]);
        s1_g_nxt    = widen6(in_pixel_value[10:5]);
        s1_b_nxt    = widen5(in_pixel_value[4:0]);
      end
      FMT_ARGB: begin
        s1_kind_nxt = KIND_LUMA;
        s1_r_nxt    = in_pixel_value[23:16];
        s1_g_nxt    = in_pixel_value[15:8];
        s1_b_nxt    = in_pixel_value[7:0];
      end
      default: begin
        s1_nib_nxt = 4'd0;
      end
    endcase
  end

  assign s1_valid_nxt = adv ? in_valid : s1_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // payload stage, loaded on accept
  always_ff @(posedge clk) begin
    if (in_valid && adv) begin
      s1_kind_r <= s1_kind_nxt;
      s1_nib_r  <= s1_nib_nxt;
      s1_r_r    <= s1_r_nxt;
      s1_g_r    <= s1_g_nxt;
      s1_b_r    <= s1_b_nxt;
      s1_last_r <= in_last_pixel;
    end
  end

  // BT.709 luminance, rounded
  assign luma_sum = 16'(s1_r_r) * 16'd55 + 16'(s1_g_r) * 16'd183
                  + 16'(s1_b_r) * 16'd18 + 16'd128;
  assign y = (s1_kind_r == KIND_LUMA) ? luma_sum[15:8] : s1_g_r;

  // invert, round to a nibble, saturate at 15
  assign inv      = 9'd263 - {1'b0, y};
  assign gray_nib = inv[8] ? 4'hf : inv[7:4];

  assign q_data.nib  = (s1_kind_r == KIND_DIRECT) ? s1_nib_r : gray_nib;
  assign q_data.last = s1_last_r;

endmodule

/* src/pgp_queue.sv */
// ----------------------------------------------------------------------------
// pgp_queue: nibble queue between front and back
// Small register FIFO so either side can stall on its own.
// ----------------------------------------------------------------------------
module pgp_queue import pgp_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  qword_t wdata,
  output logic   full,
  input  logic   pop,
  output qword_t rdata,
  output logic   empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  qword_t           mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_FULL);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // pointer and count updates
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

/* src/pgp_back.sv */
// ----------------------------------------------------------------------------
// pgp_back: nibble packer and output register
// Pairs nibbles into bytes, low nibble first, and flushes odd last pixels.
// ----------------------------------------------------------------------------
module pgp_back import pgp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  qword_t     q_data,
  input  logic       q_empty,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_packed_byte,
  output logic       out_last_byte
);

  logic       half_r, half_nxt;
  logic [3:0] pend_r, pend_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       last_r, last_nxt;
  logic       emit;

  // pop only while the output register can take a word
  assign q_pop = !q_empty && (!out_valid_r || !out_stall);

  // packing
  always_comb begin
    half_nxt = half_r;
    pend_nxt = pend_r;
    emit     = 1'b0;
    byte_nxt = byte_r;
    last_nxt = last_r;
    if (q_pop) begin
      if (!half_r) begin
        if (!q_data.last) begin
          pend_nxt = q_data.nib;
          half_nxt = 1'b1;
        end else begin
          emit     = 1'b1;
          byte_nxt = {4'd0, q_data.nib};
          last_nxt = 1'b1;
          pend_nxt = 4'd0;
        end
      end else begin
        emit     = 1'b1;
        byte_nxt = {q_data.nib, pend_r};
        last_nxt = q_data.last;
        pend_nxt = 4'd0;
        half_nxt = 1'b0;
      end
    end
  end

  // output word valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r      <= 1'b0;
      pend_r      <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      half_r      <= half_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      byte_r <= byte_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_packed_byte = byte_r;
  assign out_last_byte   = last_r;

endmodule

/* src/pixel_to_gray4_packer_top.sv */
// Path: front stage register, nibble queue, then the byte's output register.
// Throughput: one pixel per cycle unless the queue is full (front stage and
// queue push); one packed byte per two pixels, or one for an odd last pixel.
// Reset (rst_n low, synchronous): queue and packer empty, no pending nibble,
// source_format = gray4 passthrough.
// ----------------------------------------------------------------------------
// pixel_to_gray4_packer_top: source pixel to packed 4-bit gray converter
// APB-style register port, front converter, nibble queue and byte packer.
// ----------------------------------------------------------------------------
module pixel_to_gray4_packer_top import pgp_pkg::*; #(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // pixel input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_pixel_value,
  input  logic        in_last_pixel,
  // packed output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_packed_byte,
  output logic        out_last_byte
);

  logic [2:0] fmt_r, fmt_nxt;
  logic       reg_hit;
  qword_t     q_wdata, q_rdata;
  logic       q_push, q_full, q_pop, q_empty;

  // register decode, word index in paddr[2]
  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == REG_SOURCE_FORMAT);
  assign fmt_nxt = (psel && penable && pwrite && reg_hit) ? pwdata[2:0] : fmt_r;
  assign prdata  = reg_hit ? {29'd0, fmt_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_RESET;
    end else begin
      fmt_r <= fmt_nxt;
    end
  end

  pgp_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .fmt            (fmt_r),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel_value (in_pixel_value),
    .in_last_pixel  (in_last_pixel),
    .q_push         (q_push),
    .q_data         (q_wdata),
    .q_full         (q_full)
  );

  pgp_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  pgp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_data          (q_rdata),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_packed_byte (out_packed_byte),
    .out_last_byte   (out_last_byte)
  );

endmodule

/* test/tb_pixel_to_gray4_packer_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pixel_to_gray4_packer_top: self-checking bench for the gray4 packer
// A short table of directed pixels, then random streams in every source format.
// Each accepted byte is compared with the table or a behavioral model of the
// converter and packer, randomly idling both sides in the first ten segments.
// ----------------------------------------------------------------------------
module tb_pixel_to_gray4_packer_top import pgp_pkg::*; ();

  // format codes the block leaves unused
  localparam logic [2:0] FMT_UNUSED_LO = 3'd5;
  localparam logic [2:0] FMT_UNUSED_HI = 3'd7;

  localparam int DRAIN_CYCLES = 8;
  localparam int QUIET_LIMIT  = 4000;
  localparam int SEG_COUNT    = 15;
  localparam int SEG_WORDS    = 100;
  localparam int DIR_ROWS     = 20;

  typedef struct packed {
    logic [7:0] pbyte;
    logic       last_byte;
  } gray_byte_t;

  typedef struct packed {
    logic [2:0]  fmt;
    logic [31:0] pix;
    logic        last_pix;
    logic        typed;
    gray_byte_t  want;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_pixel_value;
  logic        in_last_pixel;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_packed_byte;
  logic        out_last_byte;

  // model state: format register, half-filled byte
  logic [2:0]  fmt_shadow;
  logic [3:0]  pend_nib;
  bit          half_full;
  gray_byte_t  byte_q[$];

  dir_row_t    dir_rows [DIR_ROWS];
  int          in_idle_pct;
  int          out_stall_pct;
  int          errors;
  int          quiet_cycles;

  pixel_to_gray4_packer_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_pixel_value  (in_pixel_value),
    .in_last_pixel   (in_last_pixel),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_packed_byte (out_packed_byte),
    .out_last_byte   (out_last_byte)
  );

  always #1 clk = ~clk;

  // invert an 8-bit luma and round to a nibble, saturating at 15
  function automatic logic [3:0] inv_nibble(int unsigned y);
    int unsigned n;
    n = ((255 - (y & 255)) + 8) >> 4;
    return (n > 15) ? 4'hf : n[3:0];
  endfunction

  // convert one pixel and pack it; has_out tells if a byte completes
  task automatic pack_pixel(input logic [31:0] pix, input logic last_pix,
                            output bit has_out, output gray_byte_t res);
    int unsigned r, g, b;
    logic [3:0]  nib;
    r = 0;
    g = 0;
    b = 0;
    case (fmt_shadow)
      FMT_MONO:  nib = pix[0] ? 4'hf : 4'h0;
      FMT_GRAY4: nib = pix[3:0];
      FMT_GRAY8: nib = inv_nibble(pix[7:0]);
      FMT_RGB565: begin
        // widen 5/6-bit components to 8 bits
        r = pix[15:11];
        g = pix[10:5];
        b = pix[4:0];
        r = (r * 2106) >> 8;
        g = (g * 1036) >> 8;
        b = (b * 2106) >> 8;
        nib = inv_nibble((r * 55 + g * 183 + b * 18 + 128) >> 8);
      end
      FMT_ARGB: begin
        r = pix[23:16];
        g = pix[15:8];
        b = pix[7:0];
        nib = inv_nibble((r * 55 + g * 183 + b * 18 + 128) >> 8);
      end
      default: nib = 4'h0;
    endcase
    has_out = 1'b1;
    if (!half_full) begin
      if (!last_pix) begin
        pend_nib  = nib;
        half_full = 1'b1;
        has_out   = 1'b0;
        res       = '0;
      end else begin
        // odd last pixel flushes a half byte
        res.pbyte     = {4'h0, nib};
        res.last_byte = 1'b1;
        pend_nib      = 4'h0;
      end
    end else begin
      res.pbyte     = {nib, pend_nib};
      res.last_byte = last_pix;
      pend_nib      = 4'h0;
      half_full     = 1'b0;
    end
  endtask

  // send one pixel word; called and returns at a falling edge
  task automatic push_pixel(input logic [31:0] pix, input logic last_pix,
                            input logic typed, input gray_byte_t want);
    bit         has_out;
    gray_byte_t res;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_pixel_value <= pix;
    in_last_pixel  <= last_pix;
    do @(posedge clk); while (in_stall);
    pack_pixel(pix, last_pix, has_out, res);
    if (has_out) byte_q.push_back(typed ? want : res);
    @(negedge clk);
  endtask

  // stop sending, let every expected byte arrive and the pipe settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (byte_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // register write: setup then access cycle
  task automatic write_format(input logic [2:0] f);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_SOURCE_FORMAT, 2'b00};
    pwdata  <= {29'd0, f};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    fmt_shadow = f;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // receiver stall
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  // compare each accepted byte with the oldest expectation
  always @(posedge clk) begin : check_bytes
    gray_byte_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (byte_q.size() == 0) begin
        $error("unexpected word: packed_byte %h last_byte %b",
               out_packed_byte, out_last_byte);
        errors++;
      end else begin
        want = byte_q.pop_front();
        if (out_packed_byte !== want.pbyte) begin
          $error("packed_byte: expected %h, got %h", want.pbyte, out_packed_byte);
          errors++;
        end
        if (out_last_byte !== want.last_byte) begin
          $error("last_byte: expected %b, got %b", want.last_byte, out_last_byte);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("tb_pixel_to_gray4_packer_top failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [2:0] fmt_pick;
    clk            = 1'b0;
    rst_n          = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid       = 1'b0;
    in_pixel_value = '0;
    in_last_pixel  = 1'b0;
    out_stall      = 1'b0;
    in_idle_pct    = 0;
    out_stall_pct  = 0;
    errors         = 0;
    quiet_cycles   = 0;
    fmt_shadow     = FMT_RESET;
    pend_nib       = 4'h0;
    half_full      = 1'b0;

    // format, pixel, last, typed, expected {byte, last}
    dir_rows = '{
      // reset format passes gray4 through; even and odd bitmaps
      '{FMT_GRAY4,      32'h0000_0005, 1'b0, 1'b0, '{8'h00, 1'b0}},
      '{FMT_GRAY4,      32'h0000_000a, 1'b1, 1'b1, '{8'ha5, 1'b1}},
      '{FMT_GRAY4,      32'hffff_ffff, 1'b1, 1'b1, '{8'h0f, 1'b1}},
      // mono: only bit 0 counts, set gives full nibble
      '{FMT_MONO,       32'hffff_fffe, 1'b0, 1'b0, '{8'h00, 1'b0}},
      '{FMT_MONO,       32'h0000_0001, 1'b0, 1'b1, '{8'hf0, 1'b0}},
      '{FMT_MONO,       32'h0000_0001, 1'b1, 1'b1, '{8'h0f, 1'b1}},
      // gray8: black saturates to 15, white to 0
      '{FMT_GRAY8,      32'h0000_0000, 1'b0, 1'b0, '{8'h00, 1'b0}},
      '{FMT_GRAY8,      32'h0000_00ff, 1'b0, 1'b1, '{8'h0f, 1'b0}},
      '{FMT_GRAY8,      32'hffff_ff80, 1'b1, 1'b0, '{8'h00, 1'b0}},
      // rgb565 white, black, red with junk above bit 15
      '{FMT_RGB565,     32'h0000_ffff, 1'b0, 1'b0, '{8'h00, 1'b0}},
      '{FMT_RGB565,     32'h0000_0000, 1'b0, 1'b0, '{8'h00, 1'b0}},
      '{FMT_RGB565,     32'hffff_f800, 1'b1, 1'b0, '{8'h00, 1'b0}},
      // argb: alpha ignored
      '{FMT_ARGB,       32'h00ff_ffff, 1'b0, 1'b0, '{8'h00, 1'b0}},
      '{FMT_ARGB,       32'hff00_0000, 1'b0, 1'b0, '{8'h00, 1'b0}},
      '{FMT_ARGB,       32'h0000_ff00, 1'b1, 1'b0, '{8'h00, 1'b0}},
      // unused codes give nibble 0 but still pack
      '{FMT_UNUSED_HI,  32'hdead_beef, 1'b0, 1'b0, '{8'h00, 1'b0}},
      '{FMT_UNUSED_HI,  32'h1234_5678, 1'b1, 1'b1, '{8'h00, 1'b1}},
      '{FMT_UNUSED_LO,  32'hffff_ffff, 1'b1, 1'b1, '{8'h00, 1'b1}},
      // format change with a nibble pending
      '{FMT_GRAY4,      32'h0000_0003, 1'b0, 1'b0, '{8'h00, 1'b0}},
      '{FMT_GRAY8,      32'h0000_0000, 1'b1, 1'b0, '{8'h00, 1'b0}}
    };

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_rows[i].fmt != fmt_shadow) begin
        wait_idle();
        write_format(dir_rows[i].fmt);
      end
      push_pixel(dir_rows[i].pix, dir_rows[i].last_pix, dir_rows[i].typed,
                 dir_rows[i].want);
    end

    // random streams; format set per segment, idling per group of five
    for (int seg = 0; seg < SEG_COUNT; seg++) begin
      wait_idle();
      case (seg / 5)
        0: begin
          in_idle_pct   = 21;
          out_stall_pct = 62;
        end
        1: begin
          in_idle_pct   = 62;
          out_stall_pct = 21;
        end
        default: begin
          in_idle_pct   = 0;
          out_stall_pct = 0;
        end
      endcase
      fmt_pick = (seg < 8) ? seg[2:0] : 3'($urandom_range(7));
      write_format(fmt_pick);
      repeat (SEG_WORDS) push_pixel($urandom, ($urandom_range(7) == 0), 1'b0, '0);
    end

    wait_idle();
    if (errors == 0) begin
      $display("tb_pixel_to_gray4_packer_top passed");
    end else begin
      $display("tb_pixel_to_gray4_packer_top failed");
    end
    $finish;
  end

endmodule
